### rtl/trc_pkg.sv
// shared types, widths and register codes for the textured rectangle clipper
package trc_pkg;

    localparam int CRD_W     = 32;
    localparam int TEX_W     = 17;
    localparam int LOC_W     = CRD_W + 1;
    localparam int SPAN_W    = CRD_W + 3;
    localparam int REM_W     = SPAN_W;
    localparam int DEN_W     = SPAN_W - 1;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = FRAC_W;
    localparam int PROD_W    = 2 * TEX_W;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [TEX_W-1:0] ONE_Q16 = TEX_W'(1 << FRAC_W);

    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MIN_Y = 2'd1;
    localparam logic [1:0] REG_MAX_X = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    localparam logic signed [CRD_W-1:0] RST_MIN = {1'b1, {(CRD_W-1){1'b0}}};
    localparam logic signed [CRD_W-1:0] RST_MAX = {1'b0, {(CRD_W-1){1'b1}}};

    typedef struct packed {
        logic signed [CRD_W-1:0] pos_x;
        logic signed [CRD_W-1:0] pos_y;
        logic signed [CRD_W-1:0] rect_left;
        logic signed [CRD_W-1:0] rect_right;
        logic signed [CRD_W-1:0] rect_top;
        logic signed [CRD_W-1:0] rect_bottom;
        logic [TEX_W-1:0]        tex_u_left;
        logic [TEX_W-1:0]        tex_u_right;
        logic [TEX_W-1:0]        tex_v_top;
        logic [TEX_W-1:0]        tex_v_bottom;
    } item_t;

    typedef struct packed {
        logic                    visible;
        logic signed [CRD_W-1:0] out_left;
        logic signed [CRD_W-1:0] out_right;
        logic signed [CRD_W-1:0] out_top;
        logic signed [CRD_W-1:0] out_bottom;
        logic [TEX_W-1:0]        out_u_left;
        logic [TEX_W-1:0]        out_u_right;
        logic [TEX_W-1:0]        out_v_top;
        logic [TEX_W-1:0]        out_v_bottom;
    } result_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] min_x;
        logic signed [CRD_W-1:0] min_y;
        logic signed [CRD_W-1:0] max_x;
        logic signed [CRD_W-1:0] max_y;
    } cfg_t;

    // per item control and payload that rides along the divider lanes
    typedef struct packed {
        logic                    visible;
        logic                    clip_l;
        logic                    clip_r;
        logic                    clip_t;
        logic                    clip_b;
        logic signed [CRD_W-1:0] left;
        logic signed [CRD_W-1:0] right;
        logic signed [CRD_W-1:0] top;
        logic signed [CRD_W-1:0] bottom;
        logic [TEX_W-1:0]        ul;
        logic [TEX_W-1:0]        ur;
        logic [TEX_W-1:0]        vt;
        logic [TEX_W-1:0]        vb;
    } side_t;

    typedef struct packed {
        logic              zero;
        logic              one;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [FRAC_W-1:0] quo;
    } div_t;

endpackage

### rtl/trc_regs.sv
// apb register file holding the world space clip window
module trc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [trc_pkg::ADDR_W-1:0] paddr,
    input  logic [trc_pkg::DATA_W-1:0] pwdata,
    output logic [trc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output trc_pkg::cfg_t              cfg
);
    import trc_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] sel;
    logic       wr;

    assign sel    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x <= RST_MIN;
            cfg_reg.min_y <= RST_MIN;
            cfg_reg.max_x <= RST_MAX;
            cfg_reg.max_y <= RST_MAX;
        end
        else if (wr)
        begin
            case (sel)
                REG_MIN_X: cfg_reg.min_x <= pwdata;
                REG_MIN_Y: cfg_reg.min_y <= pwdata;
                REG_MAX_X: cfg_reg.max_x <= pwdata;
                REG_MAX_Y: cfg_reg.max_y <= pwdata;
                default:   cfg_reg.min_x <= cfg_reg.min_x;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_MIN_X: prdata = cfg_reg.min_x;
            REG_MIN_Y: prdata = cfg_reg.min_y;
            REG_MAX_X: prdata = cfg_reg.max_x;
            REG_MAX_Y: prdata = cfg_reg.max_y;
            default:   prdata = '0;
        endcase
    end

endmodule

### rtl/trc_setup.sv
// three setup stages: local window, overlap and clip decisions, divider operands
module trc_setup (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           v_in,
    input  trc_pkg::item_t item,
    input  trc_pkg::cfg_t  cfg,
    output logic           v_out,
    output trc_pkg::side_t side,
    output trc_pkg::div_t  dl,
    output trc_pkg::div_t  dr,
    output trc_pkg::div_t  dt,
    output trc_pkg::div_t  db
);
    import trc_pkg::*;

    // stage 1
    logic                    v1_reg;
    item_t                   it1_reg;
    logic signed [LOC_W-1:0] tmin_x_reg, tmin_y_reg, tmax_x_reg, tmax_y_reg;

    // stage 2
    logic                     v2_reg;
    side_t                    s2_reg;
    logic signed [SPAN_W-1:0] num_reg [4];
    logic signed [SPAN_W-1:0] den_reg [4];

    // stage 3
    logic  v3_reg;
    side_t s3_reg;
    div_t  d3_reg [4];

    logic signed [LOC_W-1:0]  lft, rgt, tp, bot, anc_x, anc_y;
    logic                     vis, cl, cr, ct, cb;
    logic signed [SPAN_W-1:0] num_next [4];
    logic signed [SPAN_W-1:0] den_next [4];
    side_t                    s2_next;
    div_t                     d3_next [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg    <= item;
            tmin_x_reg <= $signed({cfg.min_x[CRD_W-1], cfg.min_x})
                          - $signed({item.pos_x[CRD_W-1], item.pos_x});
            tmin_y_reg <= $signed({cfg.min_y[CRD_W-1], cfg.min_y})
                          - $signed({item.pos_y[CRD_W-1], item.pos_y});
            tmax_x_reg <= $signed({cfg.max_x[CRD_W-1], cfg.max_x})
                          - $signed({item.pos_x[CRD_W-1], item.pos_x});
            tmax_y_reg <= $signed({cfg.max_y[CRD_W-1], cfg.max_y})
                          - $signed({item.pos_y[CRD_W-1], item.pos_y});
        end
    end

    always_comb
    begin
        lft = $signed({it1_reg.rect_left[CRD_W-1], it1_reg.rect_left});
        rgt = $signed({it1_reg.rect_right[CRD_W-1], it1_reg.rect_right});
        tp  = $signed({it1_reg.rect_top[CRD_W-1], it1_reg.rect_top});
        bot = $signed({it1_reg.rect_bottom[CRD_W-1], it1_reg.rect_bottom});
        vis = !(lft > tmax_x_reg || rgt < tmin_x_reg || tp > tmax_y_reg || bot < tmin_y_reg);
        cl  = vis && (lft < tmin_x_reg);
        cr  = vis && (rgt > tmax_x_reg);
        ct  = vis && (tp < tmin_y_reg);
        cb  = vis && (bot > tmax_y_reg);
        // right and bottom spans are anchored on the clipped left and top
        anc_x = cl ? tmin_x_reg : lft;
        anc_y = ct ? tmin_y_reg : tp;

        num_next[0] = $signed({{2{tmin_x_reg[LOC_W-1]}}, tmin_x_reg})
                      - $signed({{2{lft[LOC_W-1]}}, lft});
        den_next[0] = $signed({{2{rgt[LOC_W-1]}}, rgt}) - $signed({{2{lft[LOC_W-1]}}, lft});
        num_next[1] = $signed({{2{tmax_x_reg[LOC_W-1]}}, tmax_x_reg})
                      - $signed({{2{anc_x[LOC_W-1]}}, anc_x});
        den_next[1] = $signed({{2{rgt[LOC_W-1]}}, rgt}) - $signed({{2{anc_x[LOC_W-1]}}, anc_x});
        num_next[2] = $signed({{2{tmin_y_reg[LOC_W-1]}}, tmin_y_reg})
                      - $signed({{2{tp[LOC_W-1]}}, tp});
        den_next[2] = $signed({{2{bot[LOC_W-1]}}, bot}) - $signed({{2{tp[LOC_W-1]}}, tp});
        num_next[3] = $signed({{2{tmax_y_reg[LOC_W-1]}}, tmax_y_reg})
                      - $signed({{2{anc_y[LOC_W-1]}}, anc_y});
        den_next[3] = $signed({{2{bot[LOC_W-1]}}, bot}) - $signed({{2{anc_y[LOC_W-1]}}, anc_y});

        s2_next.visible = vis;
        s2_next.clip_l  = cl;
        s2_next.clip_r  = cr;
        s2_next.clip_t  = ct;
        s2_next.clip_b  = cb;
        s2_next.left    = cl ? tmin_x_reg[CRD_W-1:0] : it1_reg.rect_left;
        s2_next.right   = cr ? tmax_x_reg[CRD_W-1:0] : it1_reg.rect_right;
        s2_next.top     = ct ? tmin_y_reg[CRD_W-1:0] : it1_reg.rect_top;
        s2_next.bottom  = cb ? tmax_y_reg[CRD_W-1:0] : it1_reg.rect_bottom;
        s2_next.ul      = it1_reg.tex_u_left;
        s2_next.ur      = it1_reg.tex_u_right;
        s2_next.vt      = it1_reg.tex_v_top;
        s2_next.vb      = it1_reg.tex_v_bottom;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
            for (int k = 0; k < 4; k++)
            begin
                num_reg[k] <= num_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    // saturate to 0 or 1.0 outside the open interval, else start the division
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            d3_next[k].zero = num_reg[k][SPAN_W-1] || (num_reg[k] == '0);
            d3_next[k].one  = !d3_next[k].zero && (num_reg[k] >= den_reg[k]);
            d3_next[k].rem  = num_reg[k];
            d3_next[k].den  = den_reg[k][DEN_W-1:0];
            d3_next[k].quo  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s2_reg;
            for (int k = 0; k < 4; k++)
            begin
                d3_reg[k] <= d3_next[k];
            end
        end
    end

    assign v_out = v3_reg;
    assign side  = s3_reg;
    assign dl    = d3_reg[0];
    assign dr    = d3_reg[1];
    assign dt    = d3_reg[2];
    assign db    = d3_reg[3];

endmodule

### rtl/trc_div.sv
// pipelined restoring divider lane, one quotient bit per stage, q1.16 factor out
module trc_div (
    input  logic                      clk,
    input  logic                      en,
    input  trc_pkg::div_t             d_in,
    output logic [trc_pkg::TEX_W-1:0] factor
);
    import trc_pkg::*;

    div_t stage_reg [DIV_STEPS];
    div_t last;

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_step
            div_t             src;
            div_t             nxt;
            logic [REM_W-1:0] shifted;
            logic             ge;

            if (i == 0)
            begin : g_first
                assign src = d_in;
            end
            else
            begin : g_rest
                assign src = stage_reg[i-1];
            end

            always_comb
            begin
                shifted  = {src.rem[REM_W-2:0], 1'b0};
                ge       = shifted >= {1'b0, src.den};
                nxt      = src;
                nxt.rem  = ge ? shifted - {1'b0, src.den} : shifted;
                nxt.quo  = {src.quo[FRAC_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    stage_reg[i] <= nxt;
                end
            end
        end
    endgenerate

    assign last   = stage_reg[DIV_STEPS-1];
    assign factor = last.one ? ONE_Q16 : (last.zero ? '0 : {1'b0, last.quo});

endmodule

### rtl/trc_blend.sv
// texture blend stages: left and top first, then right and bottom on the new anchors
module trc_blend (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      v_in,
    input  trc_pkg::side_t            side,
    input  logic [trc_pkg::TEX_W-1:0] fl,
    input  logic [trc_pkg::TEX_W-1:0] fr,
    input  logic [trc_pkg::TEX_W-1:0] ft,
    input  logic [trc_pkg::TEX_W-1:0] fb,
    output logic                      v_out,
    output trc_pkg::result_t          result
);
    import trc_pkg::*;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    side_t             s1_reg, s2_reg, s3_reg;
    logic [TEX_W-1:0]  fr1_reg, fb1_reg, fr2_reg, fb2_reg;
    logic [PROD_W-1:0] pla_reg, plb_reg, pta_reg, ptb_reg;
    logic [PROD_W-1:0] pra_reg, prb_reg, pba_reg, pbb_reg;
    result_t           res_reg;

    logic [PROD_W:0]   sum_l, sum_t, sum_r, sum_b;
    side_t             s2_next;
    result_t           res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= side;
            fr1_reg <= fr;
            fb1_reg <= fb;
            pla_reg <= PROD_W'(ONE_Q16 - fl) * PROD_W'(side.ul);
            plb_reg <= PROD_W'(fl) * PROD_W'(side.ur);
            pta_reg <= PROD_W'(ONE_Q16 - ft) * PROD_W'(side.vt);
            ptb_reg <= PROD_W'(ft) * PROD_W'(side.vb);
        end
    end

    always_comb
    begin
        sum_l      = {1'b0, pla_reg} + {1'b0, plb_reg};
        sum_t      = {1'b0, pta_reg} + {1'b0, ptb_reg};
        s2_next    = s1_reg;
        s2_next.ul = s1_reg.clip_l ? sum_l[FRAC_W+TEX_W-1:FRAC_W] : s1_reg.ul;
        s2_next.vt = s1_reg.clip_t ? sum_t[FRAC_W+TEX_W-1:FRAC_W] : s1_reg.vt;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg  <= s2_next;
            fr2_reg <= fr1_reg;
            fb2_reg <= fb1_reg;
            s3_reg  <= s2_reg;
            pra_reg <= PROD_W'(ONE_Q16 - fr2_reg) * PROD_W'(s2_reg.ul);
            prb_reg <= PROD_W'(fr2_reg) * PROD_W'(s2_reg.ur);
            pba_reg <= PROD_W'(ONE_Q16 - fb2_reg) * PROD_W'(s2_reg.vt);
            pbb_reg <= PROD_W'(fb2_reg) * PROD_W'(s2_reg.vb);
        end
    end

    always_comb
    begin
        sum_r                 = {1'b0, pra_reg} + {1'b0, prb_reg};
        sum_b                 = {1'b0, pba_reg} + {1'b0, pbb_reg};
        res_next.visible      = s3_reg.visible;
        res_next.out_left     = s3_reg.left;
        res_next.out_right    = s3_reg.right;
        res_next.out_top      = s3_reg.top;
        res_next.out_bottom   = s3_reg.bottom;
        res_next.out_u_left   = s3_reg.ul;
        res_next.out_u_right  = s3_reg.clip_r ? sum_r[FRAC_W+TEX_W-1:FRAC_W] : s3_reg.ur;
        res_next.out_v_top    = s3_reg.vt;
        res_next.out_v_bottom = s3_reg.clip_b ? sum_b[FRAC_W+TEX_W-1:FRAC_W] : s3_reg.vb;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign v_out  = v4_reg;
    assign result = res_reg;

endmodule

### rtl/textured_rect_clip.sv
// textured rectangle clipper top level: setup, four divider lanes, texture blend
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_ready     item_t
//  result    out        result_valid / result_ready result_t
//  config    in         apb psel/penable/pwrite     4 x 32 bit window registers
//
// one item per cycle while results are taken; stages: 3 setup, 16 divider bit stages, 4 blend
// the four divider lanes run in parallel, one quotient bit per stage
// reset clears all valid bits and loads the window to the full coordinate range
// a result not taken freezes the whole pipe; item_ready follows !result_valid || result_ready
module textured_rect_clip (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  trc_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output trc_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [trc_pkg::ADDR_W-1:0] paddr,
    input  logic [trc_pkg::DATA_W-1:0] pwdata,
    output logic [trc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import trc_pkg::*;

    cfg_t             cfg;
    logic             en;
    logic             sv;
    side_t            ss;
    div_t             dl, dr, dt, db;
    logic [TEX_W-1:0] fl, fr, ft, fb;

    logic [DIV_STEPS-1:0] dv_reg;
    side_t                sd_reg [DIV_STEPS];

    assign en         = !result_valid || result_ready;
    assign item_ready = en;

    trc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trc_setup u_setup (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_in  (item_valid),
        .item  (item),
        .cfg   (cfg),
        .v_out (sv),
        .side  (ss),
        .dl    (dl),
        .dr    (dr),
        .dt    (dt),
        .db    (db)
    );

    trc_div u_div_l (.clk(clk), .en(en), .d_in(dl), .factor(fl));
    trc_div u_div_r (.clk(clk), .en(en), .d_in(dr), .factor(fr));
    trc_div u_div_t (.clk(clk), .en(en), .d_in(dt), .factor(ft));
    trc_div u_div_b (.clk(clk), .en(en), .d_in(db), .factor(fb));

    // sideband follows the divider lanes stage for stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (en)
        begin
            dv_reg <= {dv_reg[DIV_STEPS-2:0], sv};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= ss;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    trc_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .v_in   (dv_reg[DIV_STEPS-1]),
        .side   (sd_reg[DIV_STEPS-1]),
        .fl     (fl),
        .fr     (fr),
        .ft     (ft),
        .fb     (fb),
        .v_out  (result_valid),
        .result (result)
    );

endmodule

### rtl/trc_checker.sv
// port level checks for the textured rectangle clipper, bound to the top level
module trc_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_ready,
    input  logic             result_valid,
    input  logic             result_ready,
    input  trc_pkg::result_t result,
    input  logic             pready
);
    import trc_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // input side only waits on a blocked output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready == (!result_valid || result_ready))
        else $error("item_ready does not follow output stall");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // no result comes out of reset
    a_reset: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid right after reset");

endmodule

bind textured_rect_clip trc_checker u_trc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .pready       (pready)
);

### verif/tb_textured_rect_clip.sv
// testbench for the textured rectangle clipper: apb window setup, random items, scoreboard
module tb_textured_rect_clip;
    timeunit 1ns;
    timeprecision 1ps;
    import trc_pkg::*;

    // expected clip results in order of acceptance
    class clip_scoreboard;
        result_t pending[$];
        logic signed [CRD_W-1:0] win_min_x = RST_MIN;
        logic signed [CRD_W-1:0] win_min_y = RST_MIN;
        logic signed [CRD_W-1:0] win_max_x = RST_MAX;
        logic signed [CRD_W-1:0] win_max_y = RST_MAX;
        int errors = 0;

        function longint unsigned edge_factor(longint t, longint a, longint e);
            longint num;
            longint den;
            num = t - a;
            den = e - a;
            if (num <= 0)
                return 0;
            if (num >= den)
                return 65536;
            return (longint'(num) << 16) / den;
        endfunction

        function logic [TEX_W-1:0] mix_tex(longint unsigned ta, longint unsigned tt,
                                           longint unsigned f);
            longint unsigned s;
            s = ((65536 - f) * ta + f * tt) >> 16;
            return s[TEX_W-1:0];
        endfunction

        function void note_item(item_t it);
            result_t r;
            longint lmin_x, lmin_y, lmax_x, lmax_y, l, rr, t, b;
            longint unsigned ul, ur, vt, vb;
            lmin_x = longint'(win_min_x) - longint'(it.pos_x);
            lmin_y = longint'(win_min_y) - longint'(it.pos_y);
            lmax_x = longint'(win_max_x) - longint'(it.pos_x);
            lmax_y = longint'(win_max_y) - longint'(it.pos_y);
            l = it.rect_left;
            rr = it.rect_right;
            t = it.rect_top;
            b = it.rect_bottom;
            ul = it.tex_u_left;
            ur = it.tex_u_right;
            vt = it.tex_v_top;
            vb = it.tex_v_bottom;
            r.visible = !(l > lmax_x || rr < lmin_x || t > lmax_y || b < lmin_y);
            if (r.visible)
            begin
                if (l < lmin_x)
                begin
                    ul = mix_tex(ul, ur, edge_factor(lmin_x, l, rr));
                    l = lmin_x;
                end
                if (rr > lmax_x)
                begin
                    ur = mix_tex(ul, ur, edge_factor(lmax_x, l, rr));
                    rr = lmax_x;
                end
                if (t < lmin_y)
                begin
                    vt = mix_tex(vt, vb, edge_factor(lmin_y, t, b));
                    t = lmin_y;
                end
                if (b > lmax_y)
                begin
                    vb = mix_tex(vt, vb, edge_factor(lmax_y, t, b));
                    b = lmax_y;
                end
            end
            r.out_left = l[31:0];
            r.out_right = rr[31:0];
            r.out_top = t[31:0];
            r.out_bottom = b[31:0];
            r.out_u_left = ul[16:0];
            r.out_u_right = ur[16:0];
            r.out_v_top = vt[16:0];
            r.out_v_bottom = vb[16:0];
            pending.push_back(r);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(result_t got);
            result_t w;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.visible !== w.visible) report("visible", got.visible, w.visible);
            if (got.out_left !== w.out_left) report("out_left", got.out_left, w.out_left);
            if (got.out_right !== w.out_right) report("out_right", got.out_right, w.out_right);
            if (got.out_top !== w.out_top) report("out_top", got.out_top, w.out_top);
            if (got.out_bottom !== w.out_bottom)
                report("out_bottom", got.out_bottom, w.out_bottom);
            if (got.out_u_left !== w.out_u_left)
                report("out_u_left", got.out_u_left, w.out_u_left);
            if (got.out_u_right !== w.out_u_right)
                report("out_u_right", got.out_u_right, w.out_u_right);
            if (got.out_v_top !== w.out_v_top) report("out_v_top", got.out_v_top, w.out_v_top);
            if (got.out_v_bottom !== w.out_v_bottom)
                report("out_v_bottom", got.out_v_bottom, w.out_v_bottom);
        endtask
    endclass

    logic clk, rst_n;
    logic item_valid, item_ready, result_valid, result_ready;
    item_t item;
    result_t result;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;

    clip_scoreboard sb = new();
    bit calm_out = 0;
    bit hold_out = 0;
    int idle_cycles = 0;

    textured_rect_clip u_top (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
    end

    // output side: random stalls, a calm stretch and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(result);
            if (item_valid && item_ready)
                idle_cycles <= 0;
            else if (result_valid && result_ready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            result_ready <= !hold_out && (calm_out || $urandom_range(99) >= 16);
        end
    end

    initial
    begin
        wait (idle_cycles > 20000);
        $display("tb_textured_rect_clip failed");
        $finish;
    end

    // leaves psel high between back to back writes; set_window closes the burst
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        case (idx)
            REG_MIN_X: sb.win_min_x = val;
            REG_MIN_Y: sb.win_min_y = val;
            REG_MAX_X: sb.win_max_x = val;
            default:   sb.win_max_y = val;
        endcase
    endtask

    task automatic set_window(logic [31:0] x0, logic [31:0] y0,
                              logic [31:0] x1, logic [31:0] y1);
        write_reg(REG_MIN_X, x0);
        write_reg(REG_MIN_Y, y0);
        write_reg(REG_MAX_X, x1);
        write_reg(REG_MAX_Y, y1);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // valid stays high into the next transaction; drain drops it
    task automatic send_item(item_t it, bit gaps);
        while (gaps && $urandom_range(99) < 16)
        begin
            item_valid <= 0;
            @(posedge clk);
        end
        item_valid <= 1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic drain();
        item_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7fff_ffff - $urandom_range(3);
            default: return 32'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    function automatic logic [TEX_W-1:0] rnd_tex();
        if ($urandom_range(9) == 0)
            return TEX_W'($urandom);
        if ($urandom_range(9) == 0)
            return ($urandom_range(1)) ? ONE_Q16 : '0;
        return TEX_W'($urandom_range(65536));
    endfunction

    function automatic item_t rnd_item();
        item_t it;
        logic signed [31:0] a, b;
        it.pos_x = ($urandom_range(3) == 0) ? rnd_coord()
                                            : 32'($signed($urandom_range(20000)) - 10000);
        it.pos_y = ($urandom_range(3) == 0) ? rnd_coord()
                                            : 32'($signed($urandom_range(20000)) - 10000);
        a = rnd_coord();
        b = rnd_coord();
        // mostly well-ordered edges, sometimes inverted
        if (a > b && $urandom_range(9) != 0)
        begin
            it.rect_left = b;
            it.rect_right = a;
        end
        else
        begin
            it.rect_left = a;
            it.rect_right = b;
        end
        a = rnd_coord();
        b = rnd_coord();
        if (a > b && $urandom_range(9) != 0)
        begin
            it.rect_top = b;
            it.rect_bottom = a;
        end
        else
        begin
            it.rect_top = a;
            it.rect_bottom = b;
        end
        it.tex_u_left = rnd_tex();
        it.tex_u_right = rnd_tex();
        it.tex_v_top = rnd_tex();
        it.tex_v_bottom = rnd_tex();
        return it;
    endfunction

    initial
    begin
        item_t it;
        @(posedge rst_n);
        @(posedge clk);
        // directed: full-range window, extremes
        it = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, '0, ONE_Q16, ONE_Q16, '0};
        send_item(it, 0);
        it = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff};
        send_item(it, 0);
        drain();
        set_window(32'hffff_0000, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000);
        // clipped on all four sides
        it = '{0, 0, -32'sh4_0000, 32'sh4_0000, -32'sh3_0000, 32'sh5_0000, 0, ONE_Q16, 100, 60000};
        send_item(it, 0);
        // no overlap on each side
        it = '{0, 0, 32'sh2_0000, 32'sh3_0000, 0, 10, 1, 2, 3, 4};
        send_item(it, 0);
        it = '{0, 0, -32'sh3_0000, -32'sh2_0000, 0, 10, 1, 2, 3, 4};
        send_item(it, 0);
        it = '{0, 0, 0, 10, 32'sh2_0000, 32'sh3_0000, 1, 2, 3, 4};
        send_item(it, 0);
        it = '{0, 0, 0, 10, -32'sh3_0000, -32'sh2_0000, 1, 2, 3, 4};
        send_item(it, 0);
        // inside, untouched; inverted rectangle; zero span; touching edges
        it = '{0, 0, -10, 10, -10, 10, 5, 6, 7, 8};
        send_item(it, 0);
        it = '{0, 0, 32'sh3_0000, -32'sh3_0000, 32'sh3_0000, -32'sh3_0000, 9, 99, 999, 9999};
        send_item(it, 0);
        it = '{0, 0, -32'sh2_0000, -32'sh2_0000, 32'sh1_0000, 32'sh5_0000,
               0, ONE_Q16, 0, ONE_Q16};
        send_item(it, 0);
        it = '{32'sh1_0000, -32'sh1_0000, -32'sh2_0000, 32'sh0, 32'sh0, 32'sh2_0000,
               ONE_Q16, 0, ONE_Q16, 17'h1ffff};
        send_item(it, 0);
        drain();
        // inverted window
        set_window(32'sh1_0000, 32'sh1_0000, -32'sh1_0000, -32'sh1_0000);
        it = '{0, 0, -32'sh4_0000, 32'sh4_0000, -32'sh4_0000, 32'sh4_0000,
               0, ONE_Q16, 0, ONE_Q16};
        send_item(it, 0);
        it = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 1, 1, 1, 1};
        send_item(it, 0);
        drain();
        set_window(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_item(rnd_item(), 0);
        drain();

        // random phases over several windows
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_window(-32'sh8_0000, -32'sh8_0000, 32'sh8_0000, 32'sh8_0000);
                1: set_window(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
                2: set_window($urandom, $urandom, $urandom, $urandom);
                default: set_window(32'($signed($urandom_range(200000)) - 150000),
                                    32'($signed($urandom_range(200000)) - 150000),
                                    32'($signed($urandom_range(200000)) - 50000),
                                    32'($signed($urandom_range(200000)) - 50000));
            endcase
            calm_out = (ph == 1);
            if (ph == 3)
                fork
                    begin
                        hold_out = 1;
                        repeat (200) @(posedge clk);
                        hold_out = 0;
                    end
                join_none
            for (int n = 0; n < 115; n++)
                send_item(rnd_item(), ph != 1);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_textured_rect_clip passed");
        else
            $display("tb_textured_rect_clip failed");
        $finish;
    end
endmodule
